// File: design/hrlc_pkg.sv
`default_nettype none
package hrlc_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  method_code;
		logic [11:0] uri_offset;
		logic [11:0] uri_length;
		logic [3:0]  version_major;
		logic [3:0]  version_minor;
	} out_t;

	typedef enum logic [2:0] {
		PH_METHOD,
		PH_URI,
		PH_VERSION,
		PH_WAIT_LF,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_STRUCT  = 2'd1,
		ST_METHOD  = 2'd2,
		ST_VERSION = 2'd3
	} status_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [11:0] COUNT_CAP   = 12'hFFF;
	localparam logic [3:0]  SMALL_CAP   = 4'hF;
	localparam logic [3:0]  VERSION_LEN = 4'd8;
	localparam logic [3:0]  PREFIX_LEN  = 4'd5;
	localparam logic [3:0]  MAJOR_POS   = 4'd5;
	localparam logic [3:0]  DOT_POS     = 4'd6;
	localparam logic [3:0]  MINOR_POS   = 4'd7;

	// names left-aligned in 64 bits, padded with spaces
	localparam logic [63:0] METHOD_NAME [8] = '{
		"OPTIONS ", "GET     ", "HEAD    ", "POST    ",
		"PUT     ", "DELETE  ", "TRACE   ", "CONNECT "
	};

	localparam logic [3:0] METHOD_LEN [8] = '{
		4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7
	};

	function automatic logic [7:0] method_char(input logic [2:0] k, input logic [2:0] i);
		logic [5:0] sh;
		sh = {~i, 3'b000};
		return METHOD_NAME[k][sh +: 8];
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] p);
		logic [7:0] c;
		unique case (p)
			3'd0: c = 8'h48;
			3'd1: c = 8'h54;
			3'd2: c = 8'h54;
			3'd3: c = 8'h50;
			3'd4: c = 8'h2F;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// File: design/hrlc_method.sv
`default_nettype none
module hrlc_method (
	input  wire logic [7:0] cand,
	input  wire logic [3:0] mlen,
	input  wire logic [7:0] data_byte,
	input  wire logic       word_end,
	output logic      [7:0] cand_next,
	output logic      [3:0] mlen_next
);

	always_comb begin
		cand_next = cand;
		mlen_next = mlen;
		if (word_end) begin
			// keep only the methods whose length matches exactly
			for (int k = 0; k < 8; k++) begin
				if (hrlc_pkg::METHOD_LEN[k] != mlen) begin
					cand_next[k] = 1'b0;
				end
			end
		end else begin
			for (int k = 0; k < 8; k++) begin
				if (mlen >= hrlc_pkg::METHOD_LEN[k] ||
				    hrlc_pkg::method_char(3'(k), mlen[2:0]) != data_byte) begin
					cand_next[k] = 1'b0;
				end
			end
			if (mlen < hrlc_pkg::SMALL_CAP) begin
				mlen_next = mlen + 4'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/http_request_line_checker_core.sv
// an accepted word is registered in word_s1, and its result word is registered from it into result_data
// throughput: one byte per cycle while a result held at the output does not stall the byte
// a result waiting at the output does not block the next byte unless this byte also yields
// a result word; arst_n clears all request state and both valid flags
`default_nettype none
module http_request_line_checker_core #(
	parameter int LINE_BYTES = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             line_valid,
	output logic                  line_ready,
	input  wire hrlc_pkg::in_t    line_data,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output hrlc_pkg::out_t        result_data
);

	localparam int POS_CAP_INT = (LINE_BYTES - 1 < 4095) ? (LINE_BYTES - 1) : 4095;
	localparam logic [11:0] POS_CAP = 12'(POS_CAP_INT);

	logic            valid_s1;
	hrlc_pkg::in_t   word_s1;

	hrlc_pkg::phase_t phase_q, phase_d;
	logic [11:0] pos_q, pos_d;
	logic [7:0]  cand_q, cand_d;
	logic [3:0]  mlen_q, mlen_d;
	logic [11:0] uri_start_q, uri_start_d;
	logic [11:0] uri_count_q, uri_count_d;
	logic [3:0]  vpos_q, vpos_d;
	logic        vgood_q, vgood_d;
	logic [3:0]  major_q, major_d;
	logic [3:0]  minor_q, minor_d;
	logic        sent_q, sent_d;

	logic [7:0]  cand_m;
	logic [3:0]  mlen_m;
	logic [7:0]  b;
	logic [11:0] pos_next;
	logic        emit;
	hrlc_pkg::status_t status;
	hrlc_pkg::out_t    result_d;
	logic [2:0]  code;
	logic        out_free;
	logic        retire;
	logic        step;

	assign b = word_s1.data_byte;
	assign pos_next = (pos_q < POS_CAP) ? pos_q + 12'd1 : POS_CAP;

	hrlc_method u_method (
		.cand      (cand_q),
		.mlen      (mlen_q),
		.data_byte (b),
		.word_end  (b == hrlc_pkg::CH_SPACE),
		.cand_next (cand_m),
		.mlen_next (mlen_m)
	);

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		cand_d      = cand_q;
		mlen_d      = mlen_q;
		uri_start_d = uri_start_q;
		uri_count_d = uri_count_q;
		vpos_d      = vpos_q;
		vgood_d     = vgood_q;
		major_d     = major_q;
		minor_d     = minor_q;
		sent_d      = sent_q;
		emit        = 1'b0;
		status      = hrlc_pkg::ST_STRUCT;

		if (!sent_q) begin
			if (b == hrlc_pkg::CH_NUL) begin
				emit = 1'b1;
				status = hrlc_pkg::ST_STRUCT;
			end else begin
				unique case (phase_q)
					hrlc_pkg::PH_METHOD: begin
						cand_d = cand_m;
						mlen_d = mlen_m;
						if (b == hrlc_pkg::CH_SPACE) begin
							uri_start_d = pos_next;
							phase_d = hrlc_pkg::PH_URI;
						end
					end
					hrlc_pkg::PH_URI: begin
						if (b == hrlc_pkg::CH_SPACE) begin
							phase_d = hrlc_pkg::PH_VERSION;
						end else if (uri_count_q < hrlc_pkg::COUNT_CAP) begin
							uri_count_d = uri_count_q + 12'd1;
						end
					end
					hrlc_pkg::PH_VERSION: begin
						if (b == hrlc_pkg::CH_CR) begin
							phase_d = hrlc_pkg::PH_WAIT_LF;
						end else begin
							priority if (vpos_q < hrlc_pkg::PREFIX_LEN) begin
								if (b != hrlc_pkg::prefix_char(vpos_q[2:0])) vgood_d = 1'b0;
							end else if (vpos_q == hrlc_pkg::MAJOR_POS ||
							             vpos_q == hrlc_pkg::MINOR_POS) begin
								if (b < hrlc_pkg::CH_ZERO || b > hrlc_pkg::CH_NINE) begin
									vgood_d = 1'b0;
								end else if (vpos_q == hrlc_pkg::MAJOR_POS) begin
									major_d = b[3:0];
								end else begin
									minor_d = b[3:0];
								end
							end else if (vpos_q == hrlc_pkg::DOT_POS) begin
								if (b != hrlc_pkg::CH_DOT) vgood_d = 1'b0;
							end else begin
								vgood_d = 1'b0;
							end
							if (vpos_q < hrlc_pkg::SMALL_CAP) vpos_d = vpos_q + 4'd1;
						end
					end
					hrlc_pkg::PH_WAIT_LF: begin
						emit = 1'b1;
						priority if (b != hrlc_pkg::CH_LF) status = hrlc_pkg::ST_STRUCT;
						else if (cand_q == 8'd0) status = hrlc_pkg::ST_METHOD;
						else if (!vgood_q || vpos_q != hrlc_pkg::VERSION_LEN)
							status = hrlc_pkg::ST_VERSION;
						else status = hrlc_pkg::ST_OK;
					end
					default: begin
					end
				endcase
			end
			pos_d = pos_next;
		end

		// end mark on an undecided line
		if (word_s1.end_of_string && !sent_q && !emit) begin
			emit = 1'b1;
			status = hrlc_pkg::ST_STRUCT;
		end

		if (emit) begin
			sent_d  = 1'b1;
			phase_d = hrlc_pkg::PH_DONE;
		end

		if (word_s1.end_of_string) begin
			phase_d     = hrlc_pkg::PH_METHOD;
			pos_d       = 12'd0;
			cand_d      = 8'hFF;
			mlen_d      = 4'd0;
			uri_start_d = 12'd0;
			uri_count_d = 12'd0;
			vpos_d      = 4'd0;
			vgood_d     = 1'b1;
			major_d     = 4'd0;
			minor_d     = 4'd0;
			sent_d      = 1'b0;
		end
	end

	// first surviving candidate gives the method code
	always_comb begin
		code = 3'd0;
		for (int k = 7; k >= 0; k--) begin
			if (cand_q[k]) code = 3'(k);
		end
	end

	always_comb begin
		result_d = '0;
		result_d.status = status;
		if (status != hrlc_pkg::ST_STRUCT) begin
			result_d.uri_offset = uri_start_q;
			result_d.uri_length = uri_count_q;
		end
		if (status == hrlc_pkg::ST_OK || status == hrlc_pkg::ST_VERSION) begin
			result_d.method_code = code;
		end
		if (status == hrlc_pkg::ST_OK) begin
			result_d.version_major = major_q;
			result_d.version_minor = minor_q;
		end
	end

	assign out_free   = !result_valid || result_ready;
	assign retire     = !emit || out_free;
	assign line_ready = !valid_s1 || retire;
	assign step       = valid_s1 && retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_ready) begin
			valid_s1 <= line_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_valid && line_ready) begin
			word_s1 <= line_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hrlc_pkg::PH_METHOD;
			pos_q       <= 12'd0;
			cand_q      <= 8'hFF;
			mlen_q      <= 4'd0;
			uri_start_q <= 12'd0;
			uri_count_q <= 12'd0;
			vpos_q      <= 4'd0;
			vgood_q     <= 1'b1;
			major_q     <= 4'd0;
			minor_q     <= 4'd0;
			sent_q      <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			cand_q      <= cand_d;
			mlen_q      <= mlen_d;
			uri_start_q <= uri_start_d;
			uri_count_q <= uri_count_d;
			vpos_q      <= vpos_d;
			vgood_q     <= vgood_d;
			major_q     <= major_d;
			minor_q     <= minor_d;
			sent_q      <= sent_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (step && emit) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			result_data <= result_d;
		end
	end

endmodule
`default_nettype wire

// File: tb/tb_http_request_line_checker_core.sv
`default_nettype none
module tb_http_request_line_checker_core;
	import hrlc_pkg::*;

	localparam int LINE_BYTES = 4096;
	localparam logic [11:0] POS_CAP = (LINE_BYTES - 1 < 4095) ? 12'(LINE_BYTES - 1) : 12'd4095;
	localparam int RANDOM_BYTES = 850;
	localparam int HOLD_AT = 300;
	localparam int HOLD_LEN = 400;
	localparam int DRAIN_CYCLES = 6;

	typedef enum logic [2:0] {
		M_OPTIONS, M_GET, M_HEAD, M_POST, M_PUT, M_DELETE, M_TRACE, M_CONNECT
	} method_t;

	typedef logic [7:0] bytes_t [$];

	typedef struct packed {
		in_t  word;
		logic typed;
		logic want;
		out_t res;
	} dir_row_t;

	localparam out_t NO_RESULT = '0;
	localparam int DIR_N = 23;

	// typed rows carry their verdict, the rest are checked against the line predictor
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		{{CH_NUL, 1'b0}, 1'b1, 1'b1, {ST_STRUCT, M_OPTIONS, 12'd0, 12'd0, 4'd0, 4'd0}},
		{{8'hFF, 1'b1}, 1'b1, 1'b0, NO_RESULT},
		{{8'hFF, 1'b1}, 1'b1, 1'b1, {ST_STRUCT, M_OPTIONS, 12'd0, 12'd0, 4'd0, 4'd0}},
		{{"G", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{"E", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{"T", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{CH_SPACE, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{"/", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{CH_SPACE, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{"H", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{"T", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{"T", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{"P", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{"/", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{"1", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{CH_DOT, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{"1", 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{CH_CR, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{CH_LF, 1'b1}, 1'b1, 1'b1, {ST_OK, M_GET, 12'd4, 12'd1, 4'd1, 4'd1}},
		// empty method
		{{CH_SPACE, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{CH_SPACE, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{CH_CR, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		{{CH_LF, 1'b1}, 1'b1, 1'b1, {ST_METHOD, M_OPTIONS, 12'd1, 12'd0, 4'd0, 4'd0}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic line_valid = 1'b0;
	logic line_ready;
	in_t  line_data = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_t result_data;

	http_request_line_checker_core #(
		.LINE_BYTES(LINE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.line_valid(line_valid),
		.line_ready(line_ready),
		.line_data(line_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data(result_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	string method_names [8] = '{
		"OPTIONS", "GET", "HEAD", "POST", "PUT", "DELETE", "TRACE", "CONNECT"
	};
	string version_head = "HTTP/";

	// line predictor state
	phase_t      pred_phase;
	logic [11:0] pred_pos;
	logic [7:0]  pred_cand;
	logic [3:0]  pred_mlen;
	logic [11:0] pred_ustart;
	logic [11:0] pred_ucount;
	logic [3:0]  pred_vpos;
	logic        pred_vgood;
	logic [3:0]  pred_major;
	logic [3:0]  pred_minor;
	logic        pred_done;

	out_t pending_verdicts [$];
	int   mismatches = 0;
	int   fed_count = 0;
	int   burst_left = 0;

	function automatic void clear_line();
		pred_phase = PH_METHOD;
		pred_pos = '0;
		pred_cand = 8'hFF;
		pred_mlen = '0;
		pred_ustart = '0;
		pred_ucount = '0;
		pred_vpos = '0;
		pred_vgood = 1'b1;
		pred_major = '0;
		pred_minor = '0;
		pred_done = 1'b0;
	endfunction

	function automatic out_t line_verdict(input status_t st);
		out_t r;
		r = '0;
		r.status = st;
		if (st != ST_STRUCT) begin
			r.uri_offset = pred_ustart;
			r.uri_length = pred_ucount;
		end
		if (st == ST_OK || st == ST_VERSION) begin
			for (int k = 7; k >= 0; k--)
				if (pred_cand[k])
					r.method_code = 3'(k);
		end
		if (st == ST_OK) begin
			r.version_major = pred_major;
			r.version_minor = pred_minor;
		end
		pred_done = 1'b1;
		pred_phase = PH_DONE;
		return r;
	endfunction

	function automatic logic check_line_byte(input in_t w, output out_t r);
		logic [11:0] nxt;
		logic [7:0]  b;
		logic        got;
		got = 1'b0;
		r = '0;
		b = w.data_byte;
		nxt = (pred_pos < POS_CAP) ? pred_pos + 12'd1 : POS_CAP;
		if (!pred_done) begin
			if (b == CH_NUL) begin
				r = line_verdict(ST_STRUCT);
				got = 1'b1;
			end else begin
				case (pred_phase)
					PH_METHOD: begin
						if (b == CH_SPACE) begin
							for (int k = 0; k < 8; k++)
								if (method_names[k].len() != int'(pred_mlen))
									pred_cand[k] = 1'b0;
							pred_ustart = nxt;
							pred_phase = PH_URI;
						end else begin
							for (int k = 0; k < 8; k++)
								if (int'(pred_mlen) >= method_names[k].len() ||
										method_names[k][pred_mlen] != b)
									pred_cand[k] = 1'b0;
							if (pred_mlen < SMALL_CAP)
								pred_mlen++;
						end
					end
					PH_URI: begin
						if (b == CH_SPACE)
							pred_phase = PH_VERSION;
						else if (pred_ucount < COUNT_CAP)
							pred_ucount++;
					end
					PH_VERSION: begin
						if (b == CH_CR) begin
							pred_phase = PH_WAIT_LF;
						end else begin
							if (pred_vpos < 4'd5) begin
								if (b != version_head[pred_vpos])
									pred_vgood = 1'b0;
							end else if (pred_vpos == 4'd5 || pred_vpos == 4'd7) begin
								if (b < CH_ZERO || b > CH_NINE)
									pred_vgood = 1'b0;
								else if (pred_vpos == 4'd5)
									pred_major = 4'(b - CH_ZERO);
								else
									pred_minor = 4'(b - CH_ZERO);
							end else if (pred_vpos == 4'd6) begin
								if (b != CH_DOT)
									pred_vgood = 1'b0;
							end else begin
								pred_vgood = 1'b0;
							end
							if (pred_vpos < SMALL_CAP)
								pred_vpos++;
						end
					end
					PH_WAIT_LF: begin
						if (b != CH_LF)
							r = line_verdict(ST_STRUCT);
						else if (pred_cand == 8'h00)
							r = line_verdict(ST_METHOD);
						else if (!pred_vgood || pred_vpos != 4'd8)
							r = line_verdict(ST_VERSION);
						else
							r = line_verdict(ST_OK);
						got = 1'b1;
					end
					default: ;
				endcase
			end
			pred_pos = nxt;
		end
		if (w.end_of_string) begin
			if (!pred_done) begin
				r = line_verdict(ST_STRUCT);
				got = 1'b1;
			end
			clear_line();
		end
		return got;
	endfunction

	initial clear_line();

	// predict on every accepted input word
	always @(posedge clk) begin : feed_monitor
		out_t r;
		logic got;
		if (arst_n && line_valid && line_ready) begin
			got = check_line_byte(line_data, r);
			if (fed_count < DIR_N && DIR_TAB[fed_count].typed) begin
				if (DIR_TAB[fed_count].want)
					pending_verdicts.push_back(DIR_TAB[fed_count].res);
			end else if (got) begin
				pending_verdicts.push_back(r);
			end
			fed_count++;
		end
	end

	always @(posedge clk) begin : result_monitor
		out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result word: %h", result_data);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (result_data.status != want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_data.status);
					mismatches++;
				end
				if (result_data.method_code != want.method_code) begin
					$error("method_code: expected %0d, got %0d",
						want.method_code, result_data.method_code);
					mismatches++;
				end
				if (result_data.uri_offset != want.uri_offset) begin
					$error("uri_offset: expected %0d, got %0d",
						want.uri_offset, result_data.uri_offset);
					mismatches++;
				end
				if (result_data.uri_length != want.uri_length) begin
					$error("uri_length: expected %0d, got %0d",
						want.uri_length, result_data.uri_length);
					mismatches++;
				end
				if (result_data.version_major != want.version_major) begin
					$error("version_major: expected %0d, got %0d",
						want.version_major, result_data.version_major);
					mismatches++;
				end
				if (result_data.version_minor != want.version_minor) begin
					$error("version_minor: expected %0d, got %0d",
						want.version_minor, result_data.version_minor);
					mismatches++;
				end
			end
		end
	end

	// receiver: randomly changing stall pattern, one long hold-off
	initial begin : drain_side
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 50 == 0)
				mode = $urandom_range(0, 3);
			if (cyc == HOLD_AT) begin
				result_ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else begin
				case (mode)
					0: result_ready <= 1'b1;
					1: result_ready <= 1'($urandom_range(0, 1));
					2: result_ready <= ($urandom_range(0, 3) == 0);
					default: result_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic send_word(input in_t w);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				line_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		line_valid <= 1'b1;
		line_data <= w;
		do
			@(posedge clk);
		while (!line_ready);
		burst_left--;
	endtask

	task automatic send_request(input bytes_t req);
		for (int j = 0; j < req.size(); j++)
			send_word({req[j], j == req.size() - 1});
	endtask

	function automatic logic [7:0] uri_char();
		logic [7:0] c;
		if ($urandom_range(0, 7) == 0)
			c = 8'($urandom_range(1, 255));
		else
			c = 8'($urandom_range(33, 126));
		return c;
	endfunction

	function automatic logic [7:0] digit_char();
		logic [7:0] c;
		if ($urandom_range(0, 7) == 0)
			c = 8'($urandom_range(8'h2A, 8'h40));
		else
			c = CH_ZERO + 8'($urandom_range(0, 9));
		return c;
	endfunction

	initial begin : line_side
		bytes_t req;
		int m;
		int n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_word(DIR_TAB[i].word);

		while (fed_count < RANDOM_BYTES) begin
			req.delete();
			if ($urandom_range(0, 9) < 7) begin
				// well-formed request line with random content and the odd defect
				m = $urandom_range(0, 7);
				for (int k = 0; k < method_names[m].len(); k++)
					req.push_back(method_names[m][k]);
				if ($urandom_range(0, 9) == 0)
					req[$urandom_range(0, req.size() - 1)] = 8'($urandom_range(8'h41, 8'h5A));
				req.push_back(CH_SPACE);
				n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
				repeat (n) req.push_back(uri_char());
				req.push_back(CH_SPACE);
				for (int k = 0; k < 5; k++)
					req.push_back(version_head[k]);
				req.push_back(digit_char());
				req.push_back(CH_DOT);
				req.push_back(digit_char());
				if ($urandom_range(0, 7) == 0)
					req[req.size() - 1 - $urandom_range(0, 7)] = 8'($urandom_range(1, 255));
				if ($urandom_range(0, 11) == 0)
					req.push_back(digit_char());
				else if ($urandom_range(0, 11) == 0)
					void'(req.pop_back());
				req.push_back(CH_CR);
				req.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_LF);
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 4)) req.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(1, req.size());
					while (req.size() > n)
						void'(req.pop_back());
				end
				if ($urandom_range(0, 14) == 0)
					req[$urandom_range(0, req.size() - 1)] = CH_NUL;
			end else begin
				n = $urandom_range(1, 24);
				repeat (n) begin
					case ($urandom_range(0, 3))
						0: req.push_back(CH_SPACE);
						1: req.push_back(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
						default: req.push_back(8'($urandom_range(0, 255)));
					endcase
				end
			end
			send_request(req);
		end
		line_valid <= 1'b0;
		// let the monitor take the last word before looking at the queue
		@(posedge clk);

		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : watchdog
		#3600000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
`default_nettype wire
